// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk and rst_n are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is applied.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked check that also holds during reset.
`define AST_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/tpm_pkg.sv =====
package tpm_pkg;

  // emulated square side in emulated pixels
  localparam int unsigned EMU_SIZE = 160;

  localparam int unsigned COORD_W = 12;   // physical offset within the square
  localparam int unsigned PEN_W   = 8;    // emulated coordinate
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned SIDE_W  = 12;   // EMU_SIZE * scale, at most 160 * 15
  localparam int unsigned STEP_W  = 4;    // divider step counter

  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(COORD_W);
  localparam logic [PEN_W-1:0]  EMU_V     = PEN_W'(EMU_SIZE);

  // event classes and codes
  localparam logic [15:0] EV_SYNC    = 16'd0;
  localparam logic [15:0] EV_KEYC    = 16'd1;
  localparam logic [15:0] EV_AXIS    = 16'd3;
  localparam logic [15:0] CODE_X     = 16'd53;
  localparam logic [15:0] CODE_Y     = 16'd54;
  localparam logic [15:0] CODE_TOUCH = 16'd330;

  // pen result kinds
  localparam logic PEN_DOWN_MOVE = 1'b0;
  localparam logic PEN_UP        = 1'b1;

  typedef enum logic [2:0] {
    REG_SCALE     = 3'd0,
    REG_SCR_W     = 3'd1,
    REG_SCR_H     = 3'd2,
    REG_X_OFFSET  = 3'd3,
    REG_Y_OFFSET  = 3'd4,
    REG_THROTTLE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RNG_X,
    ST_RNG_Y,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] dividend;
    logic [SCALE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [PEN_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/tpm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module tpm_div
  import tpm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [SCALE_W-1:0]  rem_r, rem_nxt;
  logic [SCALE_W-1:0]  dvs_r, dvs_nxt;
  logic [COORD_W-1:0]  quo_r, quo_nxt;

  logic [SCALE_W:0]    trial;
  logic [SCALE_W:0]    diff;
  logic                ge;

  assign trial = {rem_r, quo_r[COORD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_STEPS;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low bits suffice
      rem_nxt = ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
      quo_nxt = {quo_r[COORD_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  // quotient is below EMU_SIZE when the dividend lies inside the square
  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[PEN_W-1:0];

endmodule

// ===== hw/rtl/touch_to_pen_event_mapper_unit.sv =====
// Axis, key and unknown events, and a sync with nothing pending, are taken in the idle state.
// A pending sync runs two range checks, then for a point inside the square two divisions by
// scale on the shared divider, then a decision that loads the output register when there is a
// result; a point outside skips the divisions. A waiting result holds the decision state.
// One item at a time: in_tready is high only while idle.
// Reset (rst_n, synchronous, active low) restores configuration, control and tracking state only.
`include "assert_macros.svh"

module touch_to_pen_event_mapper_unit
  import tpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // event_code[15:0], event_value[47:16], time_ms[79:48]
  input  logic [15:0] in_tuser,   // event_type[15:0]
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pen_x[7:0], pen_y[15:8]
  output logic        out_tuser,  // pen_kind[0]
  // register writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  // configuration
  logic [SCALE_W-1:0] scale_r;
  logic [11:0]        scr_w_r, scr_h_r, x_off_r, y_off_r;
  logic [9:0]         throttle_r;

  // tracking state
  logic [31:0]        latched_x_r, latched_y_r;
  logic               touching_r, sync_pending_r, pen_was_down_r;
  logic [PEN_W-1:0]   last_x_r, last_y_r;
  logic [31:0]        last_time_r;

  // per-sync working registers
  state_t             state_r, state_nxt;
  logic [31:0]        now_r;
  logic [SIDE_W-1:0]  side_r;
  logic [SCALE_W-1:0] div_s_r;
  logic [COORD_W-1:0] rx_r, ry_r;
  logic               in_x_r, inside_r;
  logic [PEN_W-1:0]   px_r, py_r;

  // output register
  logic               out_valid_r;
  logic               out_kind_r;
  logic [PEN_W-1:0]   out_x_r, out_y_r;

  logic [15:0]        ev_code;
  logic [31:0]        ev_value;
  logic [31:0]        ev_time;
  logic               accept;
  logic               start_map;

  logic [SCALE_W-1:0] s_eff;
  logic [SIDE_W-1:0]  side_c;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign ev_code  = in_tdata[15:0];
  assign ev_value = in_tdata[47:16];
  assign ev_time  = in_tdata[79:48];
  assign accept   = in_tvalid && in_tready;
  assign start_map = accept && (in_tuser == EV_SYNC) && sync_pending_r;

  assign s_eff  = (scale_r == '0) ? SCALE_W'(1) : scale_r;
  assign side_c = {4'b0, EMU_V} * {8'b0, s_eff};

  // ---------------------------------------------------------------------------
  // Range check, one axis per cycle
  // ---------------------------------------------------------------------------
  logic               sel_y;
  logic [31:0]        rng_lat;
  logic [11:0]        rng_scr, rng_off;
  logic [11:0]        rng_diff;
  logic [12:0]        rng_base;
  logic [32:0]        rng_rel;
  logic               rng_in;

  assign sel_y   = (state_r == ST_RNG_Y);
  assign rng_lat = sel_y ? latched_y_r : latched_x_r;
  assign rng_scr = sel_y ? scr_h_r : scr_w_r;
  assign rng_off = sel_y ? y_off_r : x_off_r;

  always_comb begin
    rng_diff = rng_scr - side_r;
    if (rng_scr > side_r) begin
      rng_base = {1'b0, rng_off} + {2'b0, rng_diff[11:1]};
    end else begin
      rng_base = {1'b0, rng_off};
    end
    rng_rel = {rng_lat[31], rng_lat} - {20'b0, rng_base};
    rng_in  = !rng_rel[32] && (rng_rel[31:0] < {20'b0, side_r});
  end

  // ---------------------------------------------------------------------------
  // Pen decision
  // ---------------------------------------------------------------------------
  logic [31:0]        dt;
  logic               thr_ok;
  logic               moved;
  logic               emit;
  logic               emit_kind;
  logic               upd_last;
  logic               pen_was_down_nxt;
  logic               can_load;
  logic               out_load;

  assign dt       = now_r - last_time_r;
  assign thr_ok   = dt > {22'b0, throttle_r};
  assign moved    = (px_r != last_x_r) || (py_r != last_y_r);
  assign can_load = !out_valid_r || out_tready;

  always_comb begin
    emit             = 1'b0;
    emit_kind        = PEN_DOWN_MOVE;
    upd_last         = 1'b0;
    pen_was_down_nxt = pen_was_down_r;
    priority if (!inside_r) begin
      // release outside the square still lifts the pen
      if (pen_was_down_r && !touching_r) begin
        emit             = 1'b1;
        emit_kind        = PEN_UP;
        pen_was_down_nxt = 1'b0;
      end
    end else if (touching_r) begin
      if (!pen_was_down_r) begin
        emit             = 1'b1;
        upd_last         = 1'b1;
        pen_was_down_nxt = 1'b1;
      end else if (thr_ok && moved) begin
        emit     = 1'b1;
        upd_last = 1'b1;
      end
    end else if (pen_was_down_r) begin
      emit             = 1'b1;
      emit_kind        = PEN_UP;
      pen_was_down_nxt = 1'b0;
    end else begin
      // released and already up: nothing to report
      emit = 1'b0;
    end
  end

  assign out_load = (state_r == ST_DECIDE) && emit && can_load;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start_map) state_nxt = ST_RNG_X;
      ST_RNG_X:  state_nxt = ST_RNG_Y;
      ST_RNG_Y:  state_nxt = (in_x_r && rng_in) ? ST_DIV_X : ST_DECIDE;
      ST_DIV_X:  if (div_rsp.done) state_nxt = ST_DIV_Y;
      ST_DIV_Y:  if (div_rsp.done) state_nxt = ST_DECIDE;
      ST_DECIDE: if (!emit || can_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rx_r;
    div_req.divisor  = div_s_r;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_RNG_Y: div_req.start = in_x_r && rng_in;
      ST_DIV_X: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = ry_r;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  tpm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= SCALE_W'(1);
      scr_w_r    <= 12'd320;
      scr_h_r    <= 12'd320;
      x_off_r    <= '0;
      y_off_r    <= '0;
      throttle_r <= 10'd25;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:    scale_r    <= cfg_wdata[SCALE_W-1:0];
        REG_SCR_W:    scr_w_r    <= cfg_wdata;
        REG_SCR_H:    scr_h_r    <= cfg_wdata;
        REG_X_OFFSET: x_off_r    <= cfg_wdata;
        REG_Y_OFFSET: y_off_r    <= cfg_wdata;
        REG_THROTTLE: throttle_r <= cfg_wdata[9:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      latched_x_r    <= '0;
      latched_y_r    <= '0;
      touching_r     <= 1'b0;
      sync_pending_r <= 1'b0;
      pen_was_down_r <= 1'b0;
      last_x_r       <= '1;
      last_y_r       <= '1;
      last_time_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        priority if (in_tuser == EV_AXIS && ev_code == CODE_X) begin
          latched_x_r    <= ev_value;
          sync_pending_r <= 1'b1;
        end else if (in_tuser == EV_AXIS && ev_code == CODE_Y) begin
          latched_y_r    <= ev_value;
          sync_pending_r <= 1'b1;
        end else if (in_tuser == EV_KEYC && ev_code == CODE_TOUCH) begin
          touching_r     <= (ev_value != '0);
          sync_pending_r <= 1'b1;
        end else if (in_tuser == EV_SYNC) begin
          sync_pending_r <= 1'b0;
        end else begin
          sync_pending_r <= sync_pending_r;
        end
      end
      if ((state_r == ST_DECIDE) && (!emit || can_load)) begin
        pen_was_down_r <= pen_was_down_nxt;
        if (upd_last) begin
          last_x_r    <= px_r;
          last_y_r    <= py_r;
          last_time_r <= now_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    if (start_map) begin
      now_r   <= ev_time;
      side_r  <= side_c;
      div_s_r <= s_eff;
    end
    if (state_r == ST_RNG_X) begin
      rx_r   <= rng_rel[COORD_W-1:0];
      in_x_r <= rng_in;
    end
    if (state_r == ST_RNG_Y) begin
      ry_r     <= rng_rel[COORD_W-1:0];
      inside_r <= in_x_r && rng_in;
    end
    if (state_r == ST_DIV_X && div_rsp.done) begin
      px_r <= div_rsp.quotient;
    end
    if (state_r == ST_DIV_Y && div_rsp.done) begin
      py_r <= div_rsp.quotient;
    end
    if (out_load) begin
      out_kind_r <= emit_kind;
      out_x_r    <= (emit_kind == PEN_UP) ? '0 : px_r;
      out_y_r    <= (emit_kind == PEN_UP) ? '0 : py_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_y_r, out_x_r};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `AST_CLK(a_div_idle_on_start, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `AST_CLK(a_div_done_owner, div_rsp.done |-> (state_r == ST_DIV_X || state_r == ST_DIV_Y), "divider result with no consumer")
  `AST_CLK(a_pen_up_zero, (out_valid_r && out_kind_r == PEN_UP) |-> (out_tdata == '0), "pen up with nonzero coordinates")
  `AST_CLK(a_pen_in_square, (out_valid_r && out_kind_r == PEN_DOWN_MOVE) |-> (out_x_r < EMU_V && out_y_r < EMU_V), "pen coordinate outside the square")
  `AST_CLK(a_up_clears_down, (out_load && emit_kind == PEN_UP) |=> !pen_was_down_r, "pen still down after pen up")

endmodule

// ===== bench/touch_to_pen_event_mapper_unit_test.sv =====
`timescale 1ns / 1ps

module touch_to_pen_event_mapper_unit_test
  import tpm_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT   = 800000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [2:0]  REG_SPARE_6   = 3'd6;
  localparam logic [2:0]  REG_SPARE_7   = 3'd7;
  localparam logic [15:0] CODE_NONE     = 16'd0;

  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] code;
    logic [31:0] value;
    logic [31:0] stamp;
  } touch_event_t;

  typedef struct {
    logic       kind;
    logic [7:0] x;
    logic [7:0] y;
  } pen_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [15:0] in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  // register copy
  logic [3:0]  cfg_scale = 4'd1;
  logic [11:0] cfg_scr_w = 12'd320;
  logic [11:0] cfg_scr_h = 12'd320;
  logic [11:0] cfg_x_off = 12'd0;
  logic [11:0] cfg_y_off = 12'd0;
  logic [9:0]  cfg_throttle = 10'd25;

  // tracking state
  logic signed [31:0] touch_x = '0;
  logic signed [31:0] touch_y = '0;
  bit                 contact = 1'b0;
  bit                 sync_due = 1'b0;
  bit                 pen_is_down = 1'b0;
  logic [7:0]         last_x = 8'hFF;
  logic [7:0]         last_y = 8'hFF;
  logic [31:0]        last_move_ms = '0;

  touch_event_t touch_events[$];
  pen_result_t  pen_expected[$];
  touch_event_t next_ev;
  pen_result_t  want;
  bit           in_took = 1'b0;
  bit           calm = 1'b0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  int unsigned  cycle_count = 0;
  int           errors = 0;
  int           queued = 0;
  logic [31:0]  clock_ms = '0;

  touch_to_pen_event_mapper_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // event_code[15:0], event_value[47:16], time_ms[79:48]
    .in_tuser   (in_tuser),   // event_type[15:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // pen_x[7:0], pen_y[15:8]
    .out_tuser  (out_tuser),  // pen_kind[0]
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned eff_scale();
    return (cfg_scale == 4'd0) ? 1 : int'(cfg_scale);
  endfunction

  function automatic int unsigned square_side();
    return EMU_SIZE * eff_scale();
  endfunction

  // physical position of the square's first pixel on one axis
  function automatic longint square_origin(input bit on_y);
    int unsigned scr;
    int unsigned side;
    longint      org;
    side = square_side();
    scr = on_y ? cfg_scr_h : cfg_scr_w;
    org = on_y ? cfg_y_off : cfg_x_off;
    if (scr > side)
      org += (scr - side) / 2;
    return org;
  endfunction

  task automatic apply_touch_event(input logic [15:0] ev_type, input logic [15:0] code,
                                   input logic signed [31:0] value, input logic [31:0] now);
    pen_result_t res;
    bit          emit;
    longint      rx;
    longint      ry;
    longint      side;
    longint      s;
    logic [7:0]  px;
    logic [7:0]  py;
    emit = 1'b0;
    res = '{kind: PEN_UP, x: 8'd0, y: 8'd0};
    if (ev_type == EV_AXIS) begin
      if (code == CODE_X) begin
        touch_x = value;
        sync_due = 1'b1;
      end else if (code == CODE_Y) begin
        touch_y = value;
        sync_due = 1'b1;
      end
    end else if (ev_type == EV_KEYC && code == CODE_TOUCH) begin
      contact = (value != 0);
      sync_due = 1'b1;
    end else if (ev_type == EV_SYNC && sync_due) begin
      sync_due = 1'b0;
      s = longint'(eff_scale());
      side = longint'(square_side());
      rx = longint'(touch_x) - square_origin(1'b0);
      ry = longint'(touch_y) - square_origin(1'b1);
      if (rx < 0 || rx >= side || ry < 0 || ry >= side) begin
        // outside the square only a release counts
        if (pen_is_down && !contact) begin
          pen_is_down = 1'b0;
          emit = 1'b1;
        end
      end else begin
        px = 8'(rx / s);
        py = 8'(ry / s);
        if (contact) begin
          if (!pen_is_down || (32'(now - last_move_ms) > cfg_throttle &&
                               (px != last_x || py != last_y))) begin
            pen_is_down = 1'b1;
            last_x = px;
            last_y = py;
            last_move_ms = now;
            emit = 1'b1;
            res = '{kind: PEN_DOWN_MOVE, x: px, y: py};
          end
        end else if (pen_is_down) begin
          pen_is_down = 1'b0;
          emit = 1'b1;
        end
      end
    end
    if (emit)
      pen_expected.push_back(res);
  endtask

  // input and output handshakes, sampled at the rising edge
  always @(posedge clk) begin
    in_took = rst_n && in_tvalid && in_tready;
    if (in_took)
      apply_touch_event(in_tuser, in_tdata[15:0], in_tdata[47:16], in_tdata[79:48]);
    if (rst_n && out_tvalid && out_tready) begin
      if (pen_expected.size() == 0) begin
        $error("unexpected pen transaction: pen_kind %0d pen_x %0d pen_y %0d",
               out_tuser, out_tdata[7:0], out_tdata[15:8]);
        errors++;
      end else begin
        want = pen_expected.pop_front();
        if (out_tuser !== want.kind) begin
          $error("pen_kind: expected %0d, got %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== want.x) begin
          $error("pen_x: expected %0d, got %0d", want.x, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== want.y) begin
          $error("pen_y: expected %0d, got %0d", want.y, out_tdata[15:8]);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold until the transaction is taken
    end else if (send_gap != 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (touch_events.size() != 0) begin
      next_ev = touch_events.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= {next_ev.stamp, next_ev.value, next_ev.code};
      in_tuser <= next_ev.ev_type;
      if (!calm && $urandom_range(0, 7) == 0)
        send_gap = $urandom_range(1, 16);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (recv_stall != 0) begin
      out_tready <= 1'b0;
      recv_stall--;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0)
        recv_stall = $urandom_range(1, 16);
    end
  end

  task automatic queue_event(input logic [15:0] ev_type, input logic [15:0] code,
                             input logic [31:0] value, input logic [31:0] stamp);
    touch_event_t ev;
    ev = '{ev_type: ev_type, code: code, value: value, stamp: stamp};
    touch_events.push_back(ev);
    queued++;
  endtask

  task automatic queue_sync();
    int unsigned step;
    case ($urandom_range(0, 6))
      0: step = 0;
      1: step = cfg_throttle;
      2: step = cfg_throttle + 1;
      3: step = $urandom_range(0, cfg_throttle);
      4: step = $urandom_range(cfg_throttle, 3 * cfg_throttle + 10);
      5: step = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 40);
      default: step = $urandom_range(1, 40);
    endcase
    clock_ms += step;
    queue_event(EV_SYNC, CODE_NONE, $urandom_range(0, 1) ? 32'd0 : $urandom, clock_ms);
  endtask

  function automatic logic [31:0] pick_coord(input bit on_y);
    longint      org;
    int unsigned side;
    org = square_origin(on_y);
    side = square_side();
    case ($urandom_range(0, 19))
      0: return 32'(org - 1);
      1: return 32'(org + side);
      2: return 32'(org);
      3: return 32'(org + side - 1);
      4: return $urandom;
      default: return 32'(org + $urandom_range(0, side - 1));
    endcase
  endfunction

  function automatic logic [31:0] pick_contact();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return $urandom | 32'd1;
      default: return 32'd1;
    endcase
  endfunction

  // touch, a run of frames, and in most gestures a release
  task automatic queue_gesture();
    logic [31:0] gx;
    logic [31:0] gy;
    int unsigned s;
    int unsigned moves;
    s = eff_scale();
    gx = pick_coord(1'b0);
    gy = pick_coord(1'b1);
    if ($urandom_range(0, 5) != 0)
      queue_event(EV_AXIS, CODE_X, gx, clock_ms);
    if ($urandom_range(0, 5) != 0)
      queue_event(EV_AXIS, CODE_Y, gy, clock_ms);
    queue_event(EV_KEYC, CODE_TOUCH, pick_contact(), clock_ms);
    queue_sync();
    moves = $urandom_range(0, 8);
    repeat (moves) begin
      case ($urandom_range(0, 5))
        0: begin
          gx = gx + $urandom_range(0, 2 * s) - s;
          queue_event(EV_AXIS, CODE_X, gx, clock_ms);
        end
        1: begin
          gy = gy + $urandom_range(0, 2 * s) - s;
          queue_event(EV_AXIS, CODE_Y, gy, clock_ms);
        end
        2: begin
          gx = gx + $urandom_range(0, 4 * s) - 2 * s;
          gy = gy + $urandom_range(0, 4 * s) - 2 * s;
          queue_event(EV_AXIS, CODE_X, gx, clock_ms);
          queue_event(EV_AXIS, CODE_Y, gy, clock_ms);
        end
        3: begin
          gx = pick_coord(1'b0);
          gy = pick_coord(1'b1);
          queue_event(EV_AXIS, CODE_X, gx, clock_ms);
          queue_event(EV_AXIS, CODE_Y, gy, clock_ms);
        end
        4: queue_event(EV_AXIS, CODE_X, gx, clock_ms);
        default: queue_event(EV_KEYC, CODE_TOUCH, pick_contact(), clock_ms);
      endcase
      queue_sync();
    end
    if ($urandom_range(0, 7) != 0) begin
      if ($urandom_range(0, 3) == 0)
        queue_event(EV_AXIS, CODE_X, pick_coord(1'b0), clock_ms);
      queue_event(EV_KEYC, CODE_TOUCH, 32'd0, clock_ms);
      queue_sync();
    end
  endtask

  task automatic queue_noise();
    logic [15:0] t;
    logic [15:0] c;
    case ($urandom_range(0, 4))
      0: t = EV_SYNC;
      1: t = EV_KEYC;
      2: t = EV_AXIS;
      default: t = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: c = CODE_X;
      1: c = CODE_Y;
      2: c = CODE_TOUCH;
      default: c = 16'($urandom);
    endcase
    queue_event(t, c, $urandom, $urandom);
  endtask

  task automatic queue_random(input int n);
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 9) < 8)
        queue_gesture();
      else
        queue_noise();
    end
  endtask

  // wait until every event is taken and every pen result has come, then let the block settle
  task automatic drain();
    while (touch_events.size() != 0 || in_tvalid || pen_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SCALE:    cfg_scale = data[3:0];
      REG_SCR_W:    cfg_scr_w = data;
      REG_SCR_H:    cfg_scr_h = data;
      REG_X_OFFSET: cfg_x_off = data;
      REG_Y_OFFSET: cfg_y_off = data;
      REG_THROTTLE: cfg_throttle = data[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(input logic [3:0] s, input logic [11:0] w, input logic [11:0] h,
                             input logic [11:0] xo, input logic [11:0] yo,
                             input logic [9:0] thr);
    drain();
    // upper bits of the narrow registers carry junk
    write_reg(REG_SCALE, {8'($urandom), s});
    write_reg(REG_SCR_W, w);
    write_reg(REG_SCR_H, h);
    write_reg(REG_X_OFFSET, xo);
    write_reg(REG_Y_OFFSET, yo);
    write_reg(REG_THROTTLE, {2'($urandom), thr});
    write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 12'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: square at 80..239 on both axes, throttle 25
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd0);                   // nothing pending
    queue_event(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF);  // unknown type
    queue_event(EV_AXIS, 16'hFFFF, 32'h7FFF_FFFF, 32'd0);           // unknown axis code
    queue_event(EV_KEYC, CODE_X, 32'd1, 32'd0);                     // key other than touch
    queue_event(EV_AXIS, CODE_X, 32'd80, 32'd0);
    queue_event(EV_AXIS, CODE_Y, 32'd239, 32'd0);
    queue_event(EV_KEYC, CODE_TOUCH, 32'd1, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd100);                // pen down
    queue_event(EV_AXIS, CODE_X, 32'd239, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd110);                // throttled
    queue_event(EV_AXIS, CODE_X, 32'd239, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd126);                // move
    queue_event(EV_AXIS, CODE_Y, 32'd239, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd300);                // same point
    queue_event(EV_AXIS, CODE_X, 32'h8000_0000, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd400);                // outside, still touching
    queue_event(EV_KEYC, CODE_TOUCH, 32'd0, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd410);                // release outside
    queue_event(EV_AXIS, CODE_X, 32'd100, 32'd0);
    queue_event(EV_AXIS, CODE_Y, 32'd100, 32'd0);
    queue_event(EV_KEYC, CODE_TOUCH, 32'h8000_0000, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'hFFFF_FFF0);          // down near wrap
    queue_event(EV_AXIS, CODE_X, 32'd101, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'h0000_0010);          // move across wrap
    queue_event(EV_KEYC, CODE_TOUCH, 32'd0, 32'd0);
    queue_event(EV_SYNC, CODE_NONE, 32'd0, 32'd20);                 // release inside

    clock_ms = $urandom;
    queue_random(150);
    reconfigure(4'd2, 12'd800, 12'd480, 12'd0, 12'd0, 10'd0);
    queue_random(180);
    reconfigure(4'd0, 12'd0, 12'd4095, 12'd4095, 12'd0, 10'd1000);
    queue_random(180);
    reconfigure(4'd15, 12'd4095, 12'd4095, 12'd0, 12'd4095, 10'd1023);
    queue_random(180);
    reconfigure(4'd8, 12'd1280, 12'd1280, 12'd0, 12'd0, 10'd25);
    clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
    queue_random(180);
    repeat (3) begin
      reconfigure(4'($urandom_range(0, 15)),
                  ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1600)),
                  ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 1600)),
                  12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)),
                  10'($urandom_range(0, 1023)));
      queue_random(180);
    end
    reconfigure(4'd1, 12'd320, 12'd320, 12'd12, 12'd34, 10'd5);
    calm = 1'b1;
    queue_random(180);

    drain();
    if (errors == 0 && pen_expected.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
